>>> hw/rtl/dlss_pkg.sv
// Package for the doubly linked sequence store: command and status codes.
// Used by dlss_mem and doubly_linked_sequence_store; no dependencies.
`default_nettype none
package dlss_pkg;
    typedef enum logic [3:0] {
        CMD_INS_HEAD = 4'd0,
        CMD_INS_TAIL = 4'd1,
        CMD_INS_AT   = 4'd2,
        CMD_DEL_HEAD = 4'd3,
        CMD_DEL_TAIL = 4'd4,
        CMD_DEL_AT   = 4'd5,
        CMD_SEARCH   = 4'd6,
        CMD_REVERSE  = 4'd7,
        CMD_DUMP_FWD = 4'd8,
        CMD_DUMP_REV = 4'd9
    } cmd_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
endpackage
`default_nettype wire

>>> hw/rtl/doubly_linked_sequence_store.sv
// Doubly linked sequence store, top level: sequencer around one slot memory.
// Reverse, rejects and inserts into an empty store go from dispatch straight to the
// result; head/tail inserts first fix one link, head/tail deletes first read the slot.
// Positional commands, search and dumps walk one link at a time; each dump word
// waits for a free output. One command at a time: the next word is accepted once the last
// result is taken. rst_n is asynchronous and empties the store; slot memory is not cleared.
`default_nettype none
module doubly_linked_sequence_store
    import dlss_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  command,
    input  wire logic [31:0] item_value,
    input  wire logic [4:0]  position,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [4:0]       found_position,
    output logic [31:0]      out_value,
    output logic [4:0]       element_count,
    output logic             last
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_WALK_RD, S_WALK_WT, S_FIX1_RD, S_FIX1_WT,
        S_FIX2_RD, S_FIX2_WT, S_EMIT
    } state_t;

    // Link fixups: read a slot, then rewrite one of its links.
    typedef enum logic [1:0] { FX_NONE, FX_SET_PREV, FX_SET_NEXT } fix_t;

    state_t          state_reg;
    logic [3:0]      cmd_reg;
    logic [31:0]     val_reg;
    logic [4:0]      pos_reg;
    logic [AW-1:0]   head_reg, tail_reg;
    logic [CW-1:0]   count_reg;
    logic [CAPACITY-1:0] free_reg;
    logic            rev_reg;
    logic [AW-1:0]   cur_reg;
    logic [4:0]      k_reg;
    logic [AW-1:0]   new_reg;
    logic [AW-1:0]   fa_reg, fb_reg;
    logic [AW-1:0]   fta_reg, ftb_reg;
    fix_t            fka_reg, fkb_reg;
    logic            ovalid_reg;
    logic [2:0]      ost_reg;
    logic [4:0]      ofp_reg;
    logic [31:0]     oval_reg;
    logic            olast_reg;

    logic            we;
    logic [AW-1:0]   waddr, wnext, wprev, raddr;
    logic [31:0]     wval, rval;
    logic [AW-1:0]   rnext, rprev;

    dlss_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wval(wval), .wnext(wnext),
        .wprev(wprev), .raddr(raddr), .rval(rval), .rnext(rnext), .rprev(rprev)
    );

    // Logical next/prev of the slot just read, honoring the direction flag.
    logic [AW-1:0] lnext, lprev;
    assign lnext = rev_reg ? rprev : rnext;
    assign lprev = rev_reg ? rnext : rprev;

    logic [AW-1:0] free_slot;
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (free_reg[i])
                free_slot = AW'(i);
    end

    logic full, empty;
    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);
    logic pos_ok;
    assign pos_ok = (pos_reg != 5'd0) && ({{(32-5){1'b0}}, pos_reg} <= 32'(count_reg));

    logic fixing;
    logic [AW-1:0] fix_slot;
    fix_t          fix_kind;
    logic [AW-1:0] fix_tgt;
    assign fixing  = (state_reg == S_FIX1_WT) || (state_reg == S_FIX2_WT);
    assign fix_slot = (state_reg == S_FIX2_RD) ? fb_reg : fa_reg;
    assign fix_kind = (state_reg == S_FIX2_WT) ? fkb_reg : fka_reg;
    assign fix_tgt  = (state_reg == S_FIX2_WT) ? ftb_reg : fta_reg;

    // The fixup write reuses the read-back payload, changing one link only.
    // Setting the logical prev writes the physical prev unless reversed.
    logic fx_phys_prev;
    assign fx_phys_prev = (fix_kind == FX_SET_PREV) ^ rev_reg;

    logic new_wr;
    logic [AW-1:0] new_lnext, new_lprev;
    always_comb
    begin
        raddr = cur_reg;
        if (state_reg == S_FIX1_RD || state_reg == S_FIX1_WT)
            raddr = fa_reg;
        if (state_reg == S_FIX2_RD || state_reg == S_FIX2_WT)
            raddr = fix_slot;
        we = 1'b0; waddr = fix_tgt; wval = rval; wnext = rnext; wprev = rprev;
        if (fixing && fix_kind != FX_NONE)
        begin
            we = 1'b1;
            waddr = (state_reg == S_FIX2_WT) ? fb_reg : fa_reg;
            wval = rval;
            wnext = fx_phys_prev ? rnext : fix_tgt;
            wprev = fx_phys_prev ? fix_tgt : rprev;
        end
        else if (new_wr)
        begin
            // At dispatch the new slot is not registered yet.
            we = 1'b1;
            waddr = (state_reg == S_DISPATCH) ? free_slot : new_reg;
            wval = val_reg;
            wnext = rev_reg ? new_lprev : new_lnext;
            wprev = rev_reg ? new_lnext : new_lprev;
        end
    end

    state_t        state_next;
    logic [AW-1:0] head_next, tail_next, cur_next, new_next;
    logic [AW-1:0] fa_next, fb_next, fta_next, ftb_next;
    fix_t          fka_next, fkb_next;
    logic [CW-1:0] count_next;
    logic [CAPACITY-1:0] free_next;
    logic          rev_next;
    logic [4:0]    k_next;
    logic          ovalid_next, olast_next;
    logic [2:0]    ost_next;
    logic [4:0]    ofp_next;
    logic [31:0]   oval_next;

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg; tail_next = tail_reg; cur_next = cur_reg;
        new_next = new_reg; count_next = count_reg; free_next = free_reg;
        rev_next = rev_reg; k_next = k_reg;
        fa_next = fa_reg; fb_next = fb_reg; fta_next = fta_reg; ftb_next = ftb_reg;
        fka_next = fka_reg; fkb_next = fkb_reg;
        ovalid_next = ovalid_reg; olast_next = olast_reg; ost_next = ost_reg;
        ofp_next = ofp_reg; oval_next = oval_reg;
        new_wr = 1'b0; new_lnext = '0; new_lprev = '0;
        if (out_valid && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                ost_next = ST_OK; ofp_next = '0; oval_next = '0; olast_next = 1'b1;
                fka_next = FX_NONE; fkb_next = FX_NONE;
                state_next = S_EMIT;
                case (cmd_reg)
                    CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT:
                    begin
                        if (cmd_reg == CMD_INS_AT && !pos_ok)
                            ost_next = ST_BADPOS;
                        else if (full)
                            ost_next = ST_FULL;
                        else
                        begin
                            new_next = free_slot;
                            free_next = free_reg & ~(CAPACITY'(1) << free_slot);
                            count_next = count_reg + CW'(1);
                            if (empty)
                            begin
                                head_next = free_slot; tail_next = free_slot;
                                new_wr = 1'b1; new_next = free_slot;
                            end
                            else if (cmd_reg == CMD_INS_TAIL)
                            begin
                                new_wr = 1'b1; new_lprev = tail_reg;
                                tail_next = free_slot;
                                fa_next = tail_reg; fka_next = FX_SET_NEXT;
                                fta_next = free_slot; state_next = S_FIX1_RD;
                            end
                            else if (cmd_reg == CMD_INS_HEAD || pos_reg == 5'd1)
                            begin
                                new_wr = 1'b1; new_lnext = head_reg;
                                head_next = free_slot;
                                fa_next = head_reg; fka_next = FX_SET_PREV;
                                fta_next = free_slot; state_next = S_FIX1_RD;
                            end
                            else
                            begin
                                // Walk to element pos-1, then splice after it.
                                cur_next = head_reg; k_next = 5'd1;
                                state_next = S_WALK_RD;
                            end
                        end
                    end
                    CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT:
                    begin
                        if (empty)
                            ost_next = ST_EMPTY;
                        else if (cmd_reg == CMD_DEL_AT && !pos_ok)
                            ost_next = ST_BADPOS;
                        else
                        begin
                            cur_next = (cmd_reg == CMD_DEL_TAIL ||
                                (cmd_reg == CMD_DEL_AT && 32'(pos_reg) == 32'(count_reg)
                                 && pos_reg != 5'd1)) ? tail_reg : head_reg;
                            k_next = (cmd_reg == CMD_DEL_AT && pos_reg != 5'd1 &&
                                32'(pos_reg) != 32'(count_reg)) ? 5'd1 : pos_reg;
                            if (cmd_reg != CMD_DEL_AT)
                                k_next = 5'd1;
                            state_next = S_WALK_RD;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        ost_next = ST_NOTFOUND;
                        if (!empty)
                        begin
                            cur_next = head_reg; k_next = 5'd1; state_next = S_WALK_RD;
                        end
                    end
                    CMD_REVERSE:
                    begin
                        head_next = tail_reg; tail_next = head_reg; rev_next = !rev_reg;
                    end
                    CMD_DUMP_FWD, CMD_DUMP_REV:
                    begin
                        if (empty)
                            ost_next = ST_EMPTY;
                        else
                        begin
                            cur_next = (cmd_reg == CMD_DUMP_FWD) ? head_reg : tail_reg;
                            k_next = 5'd1; state_next = S_WALK_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WALK_RD:
                state_next = S_WALK_WT;
            S_WALK_WT:
            begin
                // rval/links of cur_reg are valid now.
                case (cmd_reg)
                    CMD_INS_AT:
                    begin
                        if (k_reg + 5'd1 == pos_reg)
                        begin
                            new_wr = 1'b1; new_lprev = cur_reg; new_lnext = lnext;
                            fa_next = cur_reg; fka_next = FX_SET_NEXT; fta_next = new_reg;
                            fb_next = lnext; fkb_next = FX_SET_PREV; ftb_next = new_reg;
                            state_next = S_FIX1_RD;
                        end
                        else
                        begin
                            cur_next = lnext; k_next = k_reg + 5'd1; state_next = S_WALK_RD;
                        end
                    end
                    CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT:
                    begin
                        if (cmd_reg == CMD_DEL_AT && k_reg != pos_reg
                            && cur_reg != tail_reg)
                        begin
                            cur_next = lnext; k_next = k_reg + 5'd1; state_next = S_WALK_RD;
                        end
                        else
                        begin
                            free_next = free_reg | (CAPACITY'(1) << cur_reg);
                            count_next = count_reg - CW'(1);
                            state_next = S_EMIT;
                            if (cur_reg == head_reg && count_reg != CW'(1))
                                head_next = lnext;
                            else if (cur_reg == tail_reg && count_reg != CW'(1))
                                tail_next = lprev;
                            else if (count_reg != CW'(1))
                            begin
                                fa_next = lprev; fka_next = FX_SET_NEXT; fta_next = lnext;
                                fb_next = lnext; fkb_next = FX_SET_PREV; ftb_next = lprev;
                                state_next = S_FIX1_RD;
                            end
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (rval == val_reg)
                        begin
                            ost_next = ST_OK; ofp_next = k_reg; state_next = S_EMIT;
                        end
                        else if (32'(k_reg) >= 32'(count_reg))
                            state_next = S_EMIT;
                        else
                        begin
                            cur_next = lnext; k_next = k_reg + 5'd1; state_next = S_WALK_RD;
                        end
                    end
                    default:
                    begin
                        // Dump: hold until the output register is free.
                        if (!ovalid_next)
                        begin
                            ovalid_next = 1'b1; ost_next = ST_OK; ofp_next = '0;
                            oval_next = rval;
                            olast_next = (32'(k_reg) == 32'(count_reg));
                            cur_next = (cmd_reg == CMD_DUMP_FWD) ? lnext : lprev;
                            k_next = k_reg + 5'd1;
                            state_next = olast_next ? S_IDLE : S_WALK_RD;
                        end
                    end
                endcase
            end
            S_FIX1_RD:
                state_next = S_FIX1_WT;
            S_FIX1_WT:
                state_next = (fkb_reg == FX_NONE) ? S_EMIT : S_FIX2_RD;
            S_FIX2_RD:
                state_next = S_FIX2_WT;
            S_FIX2_WT:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1; state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0; tail_reg <= '0; count_reg <= '0;
            free_reg <= '1; rev_reg <= 1'b0; ovalid_reg <= 1'b0;
            fka_reg <= FX_NONE; fkb_reg <= FX_NONE;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next; tail_reg <= tail_next; count_reg <= count_next;
            free_reg <= free_next; rev_reg <= rev_next; ovalid_reg <= ovalid_next;
            fka_reg <= fka_next; fkb_reg <= fkb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= command; val_reg <= item_value; pos_reg <= position;
        end
        cur_reg <= cur_next; k_reg <= k_next; new_reg <= new_next;
        fa_reg <= fa_next; fb_reg <= fb_next; fta_reg <= fta_next; ftb_reg <= ftb_next;
        ost_reg <= ost_next; ofp_reg <= ofp_next; oval_reg <= oval_next;
        olast_reg <= olast_next;
    end

    // A new command waits until the previous result word has been taken, so the
    // output payload never changes while it is offered.
    assign in_ready       = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid      = ovalid_reg;
    assign status         = ost_reg;
    assign found_position = ofp_reg;
    assign out_value      = oval_reg;
    assign element_count  = 5'(count_reg);
    assign last           = olast_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("element count exceeds capacity");
    a_free_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(free_reg) + 32'(count_reg) == CAPACITY)
        else $error("free map disagrees with count");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted during a command");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/dlss_mem.sv
// Slot memory of the store: value, next link and prev link per slot.
// One write port and one registered read port. Uses dlss_pkg.
`default_nettype none
module dlss_mem
    import dlss_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int AW = 4
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wval,
    input  wire logic [AW-1:0] wnext,
    input  wire logic [AW-1:0] wprev,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rval,
    output logic [AW-1:0]      rnext,
    output logic [AW-1:0]      rprev
);
    logic [31:0]   val_mem  [CAPACITY];
    logic [AW-1:0] next_mem [CAPACITY];
    logic [AW-1:0] prev_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            val_mem[waddr]  <= wval;
            next_mem[waddr] <= wnext;
            prev_mem[waddr] <= wprev;
        end
        rval  <= val_mem[raddr];
        rnext <= next_mem[raddr];
        rprev <= prev_mem[raddr];
    end
endmodule
`default_nettype wire
